// ===== hdl/interval_overlap_reachability_assert.svh =====
// Assertion macros for the interval reachability block
`ifndef INTERVAL_OVERLAP_REACHABILITY_ASSERT_SVH
`define INTERVAL_OVERLAP_REACHABILITY_ASSERT_SVH

// same-cycle implication
`define IOR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ior: same-cycle check failed");

// next-cycle implication
`define IOR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ior: next-cycle check failed");

`endif

// ===== hdl/ior_pkg.sv =====
package ior_pkg;

    localparam int MAX_INTERVALS = 128;
    localparam int DATA_W        = 32;
    localparam int IN_IDX_W      = 7;
    localparam int IDX_W         = $clog2(MAX_INTERVALS);
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
    localparam int CMP_W         = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;

    // tests made by one probe: every cell but its own
    localparam logic [CNT_W-1:0] PROBE_HOPS = CNT_W'(MAX_INTERVALS - 1);
    // empty hops that prove no cell is left to expand
    localparam logic [CNT_W-1:0] IDLE_LIMIT = CNT_W'(MAX_INTERVALS);
    localparam logic [CNT_W-1:0] TABLE_FULL = CNT_W'(MAX_INTERVALS);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOIDX = 2'd2
    } t_status;

    // cnt: tests left while probe is set, empty hops seen otherwise
    typedef struct packed {
        logic                     present;
        logic                     probe;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic [CNT_W-1:0]         cnt;
    } t_token;

    localparam t_token TOK_FRESH = '{present: 1'b1, probe: 1'b0, lo: '0, hi: '0, cnt: '0};

    typedef struct packed {
        logic             add_go;
        logic             query_go;
        logic             fresh;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] dst;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic quiet;
    } t_ring_stat;

endpackage

// ===== hdl/ior_cell.sv =====
module ior_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr,
    input  logic                              i_live,
    input  logic                              i_clear,
    input  logic                              i_seed,
    input  logic signed [ior_pkg::DATA_W-1:0] i_left_end,
    input  logic signed [ior_pkg::DATA_W-1:0] i_right_end,
    input  ior_pkg::t_token                   i_tok,
    output ior_pkg::t_token                   o_tok,
    output logic                              o_hit
);

    logic signed [ior_pkg::DATA_W-1:0] r_lo;
    logic signed [ior_pkg::DATA_W-1:0] r_hi;
    logic                              r_seen;
    logic                              r_pending;
    logic                              r_hit;
    ior_pkg::t_token                   r_tok;

    logic                              n_seen;
    logic                              n_pending;
    logic                              n_hit;
    ior_pkg::t_token                   n_tok;
    logic                              covered;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_lo <= i_left_end;
            r_hi <= i_right_end;
        end
    end

    always_comb begin
        covered = i_live && (((i_tok.lo > r_lo) && (i_tok.lo < r_hi)) ||
                             ((i_tok.hi > r_lo) && (i_tok.hi < r_hi)));
        n_tok     = i_tok;
        n_seen    = r_seen;
        n_pending = r_pending;
        n_hit     = r_hit;
        if (i_clear) begin
            n_tok.present = 1'b0;
            n_seen        = i_seed;
            n_pending     = i_seed;
            n_hit         = 1'b0;
        end else if (i_tok.present) begin
            if (i_tok.probe) begin
                if (covered) begin
                    n_hit = 1'b1;
                    if (!r_seen) begin
                        n_seen    = 1'b1;
                        n_pending = 1'b1;
                    end
                end
                n_tok.cnt = i_tok.cnt - ior_pkg::CNT_W'(1);
                if (i_tok.cnt == ior_pkg::CNT_W'(1)) begin
                    n_tok.probe = 1'b0;
                end
            end else if (r_pending) begin
                n_pending   = 1'b0;
                n_tok.probe = 1'b1;
                n_tok.lo    = r_lo;
                n_tok.hi    = r_hi;
                n_tok.cnt   = ior_pkg::PROBE_HOPS;
            end else if (i_tok.cnt != ior_pkg::IDLE_LIMIT) begin
                n_tok.cnt = i_tok.cnt + ior_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= 1'b0;
            r_pending <= 1'b0;
            r_hit     <= 1'b0;
            r_tok     <= '0;
        end else begin
            r_seen    <= n_seen;
            r_pending <= n_pending;
            r_hit     <= n_hit;
            r_tok     <= n_tok;
        end
    end

    assign o_tok = r_tok;
    assign o_hit = r_hit;

endmodule

// ===== hdl/ior_ctrl.sv =====
module ior_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_mode,
    input  logic [ior_pkg::IN_IDX_W-1:0]  i_source_index,
    input  logic [ior_pkg::IN_IDX_W-1:0]  i_target_index,
    input  ior_pkg::t_ring_stat           i_stat,
    output logic                          o_busy,
    output logic                          o_valid,
    output logic                          o_reachable,
    output logic [1:0]                    o_status,
    output ior_pkg::t_cmd                 o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [ior_pkg::CNT_W-1:0]   r_count;
    logic [ior_pkg::IDX_W-1:0]   r_dst;
    logic                        r_fresh;
    logic                        r_valid;
    logic                        n_valid;
    logic                        r_reach;
    logic                        n_reach;
    ior_pkg::t_status            r_status;
    ior_pkg::t_status            n_status;

    logic accept;
    logic idx_ok;
    logic full;
    logic add_go;
    logic query_go;

    assign accept   = i_start && (r_state == S_IDLE);
    assign full     = (r_count == ior_pkg::TABLE_FULL);
    assign idx_ok   = (ior_pkg::CMP_W'(i_source_index) < ior_pkg::CMP_W'(r_count)) &&
                      (ior_pkg::CMP_W'(i_target_index) < ior_pkg::CMP_W'(r_count));
    assign add_go   = accept && !i_mode && !full;
    assign query_go = accept && i_mode && idx_ok;

    always_comb begin
        n_state  = r_state;
        n_valid  = 1'b0;
        n_reach  = 1'b0;
        n_status = ior_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_mode) begin
                        n_valid  = 1'b1;
                        n_status = full ? ior_pkg::ST_FULL : ior_pkg::ST_OK;
                    end else if (!idx_ok) begin
                        n_valid  = 1'b1;
                        n_status = ior_pkg::ST_NOIDX;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (i_stat.hit) begin
                    n_valid = 1'b1;
                    n_reach = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.quiet) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_fresh  <= 1'b0;
            r_valid  <= 1'b0;
            r_reach  <= 1'b0;
            r_status <= ior_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_fresh  <= query_go;
            r_valid  <= n_valid;
            r_reach  <= n_reach;
            r_status <= n_status;
            if (add_go) begin
                r_count <= r_count + ior_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (query_go) begin
            r_dst <= ior_pkg::IDX_W'(i_target_index);
        end
    end

    assign o_cmd.add_go   = add_go;
    assign o_cmd.query_go = query_go;
    assign o_cmd.fresh    = r_fresh;
    assign o_cmd.count    = r_count;
    assign o_cmd.src      = ior_pkg::IDX_W'(i_source_index);
    assign o_cmd.dst      = r_dst;

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_reachable = r_reach;
    assign o_status    = r_status;

endmodule

// ===== hdl/interval_overlap_reachability.sv =====
// Interval table with overlap-graph reachability. Each request is taken when start is high
// and busy is low; exactly one result follows as a single-cycle o_valid strobe, which the
// receiver cannot stall. Adds, table-full adds and queries naming an unstored index answer
// in the cycle after the request. A query walks a ring of MAX_INTERVALS cells, one per
// stored interval, with a single token that moves one cell per cycle: an empty token picks
// up the next interval waiting to be expanded and carries its endpoints past the other
// MAX_INTERVALS-1 cells, each of which tests them against its own interval. The answer comes
// as soon as the target is reached, or once the token makes a full empty round.
module interval_overlap_reachability (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_mode,
    input  logic signed [ior_pkg::DATA_W-1:0] i_left_end,
    input  logic signed [ior_pkg::DATA_W-1:0] i_right_end,
    input  logic [ior_pkg::IN_IDX_W-1:0]      i_source_index,
    input  logic [ior_pkg::IN_IDX_W-1:0]      i_target_index,
    output logic                              o_valid,
    output logic                              o_reachable,
    output logic [1:0]                        o_status
);

    ior_pkg::t_cmd                       w_cmd;
    ior_pkg::t_ring_stat                 w_stat;
    ior_pkg::t_token                     w_tok_out [ior_pkg::MAX_INTERVALS];
    ior_pkg::t_token                     w_tok_in  [ior_pkg::MAX_INTERVALS];
    logic [ior_pkg::MAX_INTERVALS-1:0]   w_hit;

    ior_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_mode         (i_mode),
        .i_source_index (i_source_index),
        .i_target_index (i_target_index),
        .i_stat         (w_stat),
        .o_busy         (busy),
        .o_valid        (o_valid),
        .o_reachable    (o_reachable),
        .o_status       (o_status),
        .o_cmd          (w_cmd)
    );

    assign w_tok_in[0] = w_cmd.fresh ? ior_pkg::TOK_FRESH
                                     : w_tok_out[ior_pkg::MAX_INTERVALS-1];

    for (genvar k = 0; k < ior_pkg::MAX_INTERVALS; k++) begin : g_ring
        if (k > 0) begin : g_link
            assign w_tok_in[k] = w_tok_out[k-1];
        end
        ior_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr        (w_cmd.add_go && (w_cmd.count == ior_pkg::CNT_W'(k))),
            .i_live      (ior_pkg::CNT_W'(k) < w_cmd.count),
            .i_clear     (w_cmd.query_go),
            .i_seed      (w_cmd.src == ior_pkg::IDX_W'(k)),
            .i_left_end  (i_left_end),
            .i_right_end (i_right_end),
            .i_tok       (w_tok_in[k]),
            .o_tok       (w_tok_out[k]),
            .o_hit       (w_hit[k])
        );
    end

    assign w_stat.hit   = w_hit[w_cmd.dst];
    assign w_stat.quiet = w_tok_out[ior_pkg::MAX_INTERVALS-1].present &&
                          !w_tok_out[ior_pkg::MAX_INTERVALS-1].probe &&
                          (w_tok_out[ior_pkg::MAX_INTERVALS-1].cnt == ior_pkg::IDLE_LIMIT);

endmodule

// ===== hdl/ior_checker.sv =====
`include "interval_overlap_reachability_assert.svh"

module ior_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_mode,
    input logic       o_valid,
    input logic       o_reachable,
    input logic [1:0] o_status
);

    // an add always answers in the next cycle and never reports a path
    `IOR_ASSERT_NEXT(a_add_answers, i_clk, i_rst_n, start && !busy && !i_mode, o_valid && !o_reachable)

    // a query either starts a walk or answers at once
    `IOR_ASSERT_NEXT(a_query_moves, i_clk, i_rst_n, start && !busy && i_mode, busy || o_valid)

    // no result without a request before it
    `IOR_ASSERT_NOW(a_no_stray, i_clk, i_rst_n, o_valid, $past(start && !busy) || $past(busy))

    // a found path always carries ok status
    `IOR_ASSERT_NOW(a_reach_ok, i_clk, i_rst_n, o_valid && o_reachable, o_status == ior_pkg::ST_OK)

endmodule

bind interval_overlap_reachability ior_checker u_ior_checker (.*);
